>>> hdl/cse_pkg.sv
package cse_pkg;

    localparam int unsigned TENSION_W     = 17;
    localparam int unsigned TENSION_RESET = 32768;
    localparam int unsigned COORD_W       = 32;
    localparam int unsigned U_W           = 17;
    localparam int unsigned OP_W          = 2;

    // shared multiplier operand and accumulator widths
    localparam int unsigned MUL_A_W = 39;
    localparam int unsigned MUL_B_W = 21;
    localparam int unsigned COEF_W  = 20;
    localparam int unsigned ACC_W   = 62;
    localparam int unsigned CI_W    = 38;
    localparam int unsigned WGT_W   = 20;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH = 2'd0,
        OP_POS  = 2'd1,
        OP_TAN  = 2'd2,
        OP_RSVD = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_USQ,
        ST_UCUBE,
        ST_BASIS,
        ST_BLEND,
        ST_SAT,
        ST_DONE
    } state_t;

    typedef enum logic [1:0] {
        BIAS_NONE,
        BIAS_HALF16,
        BIAS_HALF32
    } bias_t;

    typedef struct packed {
        logic  en;
        logic  load;
        bias_t bias;
    } mac_ctl_t;

    // cardinal basis matrix entry, Q.16, rows top to bottom
    function automatic logic signed [COEF_W-1:0] basis_coef(
        input logic [TENSION_W-1:0] s,
        input logic [1:0]           row,
        input logic [1:0]           col
    );
        logic signed [COEF_W-1:0] sv;
        logic signed [COEF_W-1:0] one;
        logic signed [COEF_W-1:0] r;
        sv  = signed'({{(COEF_W-TENSION_W){1'b0}}, s});
        one = COEF_W'(65536);
        r   = '0;
        case ({row, col})
            4'b00_00: r = -sv;
            4'b00_01: r = (one <<< 1) - sv;
            4'b00_10: r = sv - (one <<< 1);
            4'b00_11: r = sv;
            4'b01_00: r = sv <<< 1;
            4'b01_01: r = sv - one - (one <<< 1);
            4'b01_10: r = one + (one <<< 1) - (sv <<< 1);
            4'b01_11: r = -sv;
            4'b10_00: r = -sv;
            4'b10_10: r = sv;
            4'b11_01: r = one;
            default:  r = '0;
        endcase
        return r;
    endfunction

endpackage

>>> hdl/cardinal_spline_evaluator_core.sv
// a push or an ignored item is taken in ST_IDLE and leaves the state there; an evaluate item runs
// through ST_USQ and ST_UCUBE (weights), per coordinate ST_BASIS, ST_BLEND and ST_SAT, then ST_DONE (output)
// all products go through one shared 39x21 multiply-accumulate unit, so a new item is
// taken only when the previous one is finished, which is later while an earlier result
// still waits on m_tready
// synchronous active-low reset clears the window, sets tension to 0.5, drops any pending result
module cardinal_spline_evaluator_core (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [cse_pkg::TENSION_W-1:0]       cfg_wr_data,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [119:0]                        s_tdata,  // point_x, point_y, point_z, param_u
    input  logic [cse_pkg::OP_W-1:0]            s_tuser,  // op
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [95:0]                         m_tdata   // result_x, result_y, result_z
);

    localparam int unsigned CW = cse_pkg::COORD_W;

    cse_pkg::state_t state_reg, state_next;

    logic [cse_pkg::TENSION_W-1:0] tension_reg;
    logic [CW-1:0]                 win_reg [12];
    logic [cse_pkg::U_W-1:0]       u_reg;
    logic                          tan_reg;
    logic [17:0]                   u2_reg;
    logic [19:0]                   u3_reg;
    logic signed [cse_pkg::CI_W-1:0] ci_reg [4];
    logic [CW-1:0]                 res_reg [3];
    logic [1:0]                    coord_reg, coord_next;
    logic [1:0]                    row_reg, row_next;
    logic [1:0]                    col_reg, col_next;
    logic                          m_valid_reg;
    logic [95:0]                   m_data_reg;

    cse_pkg::mac_ctl_t                   mac_ctl;
    logic signed [cse_pkg::MUL_A_W-1:0]  mac_a;
    logic signed [cse_pkg::MUL_B_W-1:0]  mac_b;
    logic signed [cse_pkg::ACC_W-1:0]    acc_next;
    logic signed [cse_pkg::ACC_W-1:0]    acc;

    logic                    accept;
    cse_pkg::op_t            in_op;
    logic [3:0]              win_idx;
    logic [cse_pkg::WGT_W-1:0] wgt;
    logic [33:0]             u2_sum;
    logic signed [45:0]      final_sh;
    logic [CW-1:0]           final_sat;
    logic                    out_free;

    assign s_tready = (state_reg == cse_pkg::ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign in_op    = cse_pkg::op_t'(s_tuser);
    assign out_free = !m_valid_reg || m_tready;

    // window word for point col, coordinate coord
    assign win_idx = ({2'b00, col_reg} << 1) + {2'b00, col_reg} + {2'b00, coord_reg};

    always_comb begin
        wgt = '0;
        if (tan_reg) begin
            case (row_reg)
                2'd0:    wgt = {2'b00, u2_reg} + {1'b0, u2_reg, 1'b0};
                2'd1:    wgt = {2'b00, u_reg, 1'b0};
                2'd2:    wgt = 20'd65536;
                default: wgt = '0;
            endcase
        end else begin
            case (row_reg)
                2'd0:    wgt = u3_reg;
                2'd1:    wgt = {2'b00, u2_reg};
                2'd2:    wgt = {3'b000, u_reg};
                default: wgt = 20'd65536;
            endcase
        end
    end

    assign u2_sum   = acc[33:0] + 34'd32768;
    assign final_sh = acc[cse_pkg::ACC_W-1:16];

    always_comb begin
        if (final_sh > 46'sd2147483647) begin
            final_sat = 32'h7FFF_FFFF;
        end else if (final_sh < -46'sd2147483648) begin
            final_sat = 32'h8000_0000;
        end else begin
            final_sat = final_sh[CW-1:0];
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            cse_pkg::ST_IDLE: begin
                if (accept && (in_op == cse_pkg::OP_POS || in_op == cse_pkg::OP_TAN)) begin
                    state_next = cse_pkg::ST_USQ;
                end
            end
            cse_pkg::ST_USQ:   state_next = cse_pkg::ST_UCUBE;
            cse_pkg::ST_UCUBE: state_next = cse_pkg::ST_BASIS;
            cse_pkg::ST_BASIS: begin
                if (row_reg == 2'd3 && col_reg == 2'd3) begin
                    state_next = cse_pkg::ST_BLEND;
                end
            end
            cse_pkg::ST_BLEND: begin
                if (row_reg == 2'd3) begin
                    state_next = cse_pkg::ST_SAT;
                end
            end
            cse_pkg::ST_SAT: begin
                state_next = (coord_reg == 2'd2) ? cse_pkg::ST_DONE : cse_pkg::ST_BASIS;
            end
            cse_pkg::ST_DONE: begin
                if (out_free) begin
                    state_next = cse_pkg::ST_IDLE;
                end
            end
            default: state_next = cse_pkg::ST_IDLE;
        endcase
    end

    // datapath control
    always_comb begin
        mac_ctl    = '{en: 1'b0, load: 1'b0, bias: cse_pkg::BIAS_NONE};
        mac_a      = '0;
        mac_b      = '0;
        coord_next = coord_reg;
        row_next   = row_reg;
        col_next   = col_reg;
        case (state_reg)
            cse_pkg::ST_IDLE: begin
                coord_next = '0;
                row_next   = '0;
                col_next   = '0;
            end
            cse_pkg::ST_USQ: begin
                mac_ctl = '{en: 1'b1, load: 1'b1, bias: cse_pkg::BIAS_NONE};
                mac_a   = signed'({22'd0, u_reg});
                mac_b   = signed'({4'd0, u_reg});
            end
            cse_pkg::ST_UCUBE: begin
                mac_ctl = '{en: 1'b1, load: 1'b1, bias: cse_pkg::BIAS_HALF32};
                mac_a   = signed'({5'd0, acc[33:0]});
                mac_b   = signed'({4'd0, u_reg});
            end
            cse_pkg::ST_BASIS: begin
                mac_ctl  = '{en: 1'b1, load: (col_reg == 2'd0), bias: cse_pkg::BIAS_HALF16};
                mac_a    = cse_pkg::MUL_A_W'(signed'(win_reg[win_idx]));
                mac_b    = cse_pkg::MUL_B_W'(cse_pkg::basis_coef(tension_reg, row_reg, col_reg));
                col_next = col_reg + 2'd1;
                if (col_reg == 2'd3) begin
                    row_next = row_reg + 2'd1;
                end
            end
            cse_pkg::ST_BLEND: begin
                mac_ctl  = '{en: 1'b1, load: (row_reg == 2'd0), bias: cse_pkg::BIAS_HALF16};
                mac_a    = cse_pkg::MUL_A_W'(ci_reg[row_reg]);
                mac_b    = signed'({1'b0, wgt});
                row_next = row_reg + 2'd1;
            end
            cse_pkg::ST_SAT: begin
                coord_next = coord_reg + 2'd1;
                row_next   = '0;
                col_next   = '0;
            end
            cse_pkg::ST_DONE: begin
            end
            default: begin
            end
        endcase
    end

    cse_mac u_mac (
        .aclk     (aclk),
        .op_a     (mac_a),
        .op_b     (mac_b),
        .ctl      (mac_ctl),
        .acc_next (acc_next),
        .acc      (acc)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= cse_pkg::ST_IDLE;
            tension_reg <= cse_pkg::TENSION_W'(cse_pkg::TENSION_RESET);
            m_valid_reg <= 1'b0;
            coord_reg   <= '0;
            row_reg     <= '0;
            col_reg     <= '0;
            for (int i = 0; i < 12; i++) begin
                win_reg[i] <= '0;
            end
        end else begin
            state_reg <= state_next;
            coord_reg <= coord_next;
            row_reg   <= row_next;
            col_reg   <= col_next;
            if (cfg_wr_en) begin
                tension_reg <= cfg_wr_data;
            end
            if (accept && in_op == cse_pkg::OP_PUSH) begin
                for (int i = 0; i < 9; i++) begin
                    win_reg[i] <= win_reg[i+3];
                end
                win_reg[9]  <= s_tdata[31:0];
                win_reg[10] <= s_tdata[63:32];
                win_reg[11] <= s_tdata[95:64];
            end
            if (state_reg == cse_pkg::ST_DONE && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            u_reg   <= s_tdata[112:96];
            tan_reg <= (in_op == cse_pkg::OP_TAN);
        end
        if (state_reg == cse_pkg::ST_UCUBE) begin
            u2_reg <= u2_sum[33:16];
        end
        // acc still holds the rounded cube on the first basis step
        if (state_reg == cse_pkg::ST_BASIS && coord_reg == 2'd0 &&
            row_reg == 2'd0 && col_reg == 2'd0) begin
            u3_reg <= acc[51:32];
        end
        if (state_reg == cse_pkg::ST_BASIS && col_reg == 2'd3) begin
            ci_reg[row_reg] <= acc_next[53:16];
        end
        if (state_reg == cse_pkg::ST_SAT) begin
            res_reg[coord_reg] <= final_sat;
        end
        if (state_reg == cse_pkg::ST_DONE && out_free) begin
            m_data_reg <= {res_reg[2], res_reg[1], res_reg[0]};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

>>> hdl/cse_mac.sv
module cse_mac (
    input  logic                                   aclk,
    input  logic signed [cse_pkg::MUL_A_W-1:0]     op_a,
    input  logic signed [cse_pkg::MUL_B_W-1:0]     op_b,
    input  cse_pkg::mac_ctl_t                      ctl,
    output logic signed [cse_pkg::ACC_W-1:0]       acc_next,
    output logic signed [cse_pkg::ACC_W-1:0]       acc
);

    localparam int unsigned PROD_W = cse_pkg::MUL_A_W + cse_pkg::MUL_B_W;

    logic signed [PROD_W-1:0]         prod;
    logic signed [cse_pkg::ACC_W-1:0] base;
    logic signed [cse_pkg::ACC_W-1:0] acc_reg;

    assign prod = op_a * op_b;

    always_comb begin
        base = acc_reg;
        if (ctl.load) begin
            case (ctl.bias)
                cse_pkg::BIAS_HALF16: base = cse_pkg::ACC_W'(64'sd32768);
                cse_pkg::BIAS_HALF32: base = cse_pkg::ACC_W'(64'sd2147483648);
                cse_pkg::BIAS_NONE:   base = '0;
                default:              base = '0;
            endcase
        end
    end

    assign acc_next = base + cse_pkg::ACC_W'(prod);

    always_ff @(posedge aclk) begin
        if (ctl.en) begin
            acc_reg <= acc_next;
        end
    end

    assign acc = acc_reg;

endmodule
